### hdl/fixed_point_log10_assert.svh
// Assertion macros used by the checker module of the log10 block.
// Each macro samples on the rising edge of clk.
`ifndef FIXED_POINT_LOG10_ASSERT_SVH
`define FIXED_POINT_LOG10_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define FPL10_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles themselves.
`define FPL10_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/fpl10_pkg.sv
`timescale 1ns / 1ps
package fpl10_pkg;

  // Operand width and the normalizing shift count.
  localparam int INPUT_BITS = 16;
  localparam int SHIFT_W    = $clog2(INPUT_BITS);
  localparam int SPAN_W     = INPUT_BITS + 1;
  localparam int FULL_SPAN  = 1 << INPUT_BITS;

  // Scale of the gap: k = x * 10000 / 65536.
  localparam int SCALE        = 10000;
  localparam int SCALE_W      = 14;
  localparam int KSCALE_SHIFT = 16;

  // Widths of the intermediate values over the nonzero operand range.
  localparam int K_W     = 13;  // k up to 5000
  localparam int SQ_W    = 25;  // k*k up to 25e6
  localparam int K33_W   = 18;  // k*33 up to 165000
  localparam int Q20_W   = 11;  // sq/20000 up to 1250
  localparam int Q10_W   = 12;  // sq/10000 up to 2500
  localparam int Q100K_W = 8;   // sq/100000 up to 250
  localparam int Q33_W   = 11;  // k*33/100 up to 1650
  localparam int P1_W    = 22;  // product up to 4125000
  localparam int P2_W    = 16;  // product up to 62500
  localparam int P1Q_W   = 9;   // up to 412
  localparam int P2Q_W   = 8;   // up to 156
  localparam int T_W     = 13;  // series sum up to 6818
  localparam int TM_W    = 27;  // t*10000 up to 68180000
  localparam int TQ_W    = 12;  // t*10000/23025 up to 2961
  localparam int OUT_W   = 16;

  // Series and conversion constants.
  localparam int K33_MUL   = 33;
  localparam int DIV_SQ_A  = 20000;
  localparam int DIV_SQ_B  = 10000;
  localparam int DIV_SQ_C  = 100000;
  localparam int DIV_K33   = 100;
  localparam int DIV_P1    = 10000;
  localparam int DIV_P2    = 400;
  localparam int DIV_LN10  = 23025;
  localparam int LOG_TOP   = 48165;
  localparam int LOG2_STEP = 3010;

  // Truncated reciprocals: floor(2^W / d), where W covers the dividend.
  // The estimate (a * recip) >> W is the true quotient or one below it.
  localparam int RECIP_W = 16;
  localparam logic [RECIP_W-1:0] RECIP_SQ_A = RECIP_W'((64'd1 << SQ_W) / DIV_SQ_A);
  localparam logic [RECIP_W-1:0] RECIP_SQ_B = RECIP_W'((64'd1 << SQ_W) / DIV_SQ_B);
  localparam logic [RECIP_W-1:0] RECIP_SQ_C = RECIP_W'((64'd1 << SQ_W) / DIV_SQ_C);
  localparam logic [RECIP_W-1:0] RECIP_K33  = RECIP_W'((64'd1 << K33_W) / DIV_K33);
  localparam logic [RECIP_W-1:0] RECIP_P1   = RECIP_W'((64'd1 << P1_W) / DIV_P1);
  localparam logic [RECIP_W-1:0] RECIP_P2   = RECIP_W'((64'd1 << P2_W) / DIV_P2);
  localparam logic [RECIP_W-1:0] RECIP_LN10 = RECIP_W'((64'd1 << TM_W) / DIV_LN10);

  // Cycles from an accepted beat to its result strobe.
  localparam int PIPE_DEPTH = 14;

  // Control that travels with each beat down the pipeline.
  typedef struct packed {
    logic               valid;
    logic               zero;
    logic [SHIFT_W-1:0] shifts;
  } item_ctl_t;

endpackage

### hdl/fixed_point_log10.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// input     start, accepted if !busy operand     [15:0] unsigned
// result    done, one-cycle strobe   log_scaled  [15:0] unsigned
//
// A beat is taken on every clock edge where start is high and busy is low.
// Results come out one per beat, in order, after fourteen register stages,
// none of which holds more than one multiply on any path through it.
// Throughput is one beat per clock; busy is high only during reset and
// the first cycle after it. Synchronous reset clears the valid bits of
// all stages. The result side has no back pressure, so nothing ever stalls.
module fixed_point_log10 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [fpl10_pkg::INPUT_BITS-1:0]    operand,
  output logic                                done,
  output logic [fpl10_pkg::OUT_W-1:0]         log_scaled
);
  import fpl10_pkg::*;

  logic            in_valid;
  item_ctl_t       norm_ctl;
  logic [K_W-1:0]  norm_k;
  item_ctl_t       series_ctl;
  logic [T_W-1:0]  series_t;

  // The pipeline takes a beat every cycle once out of reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign in_valid = start && !busy;

  // Normalize and scale the gap.
  fpl10_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .operand  (operand),
    .out_ctl  (norm_ctl),
    .k        (norm_k)
  );

  // Four-term series for the natural logarithm.
  fpl10_series u_series (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (norm_ctl),
    .k       (norm_k),
    .out_ctl (series_ctl),
    .t       (series_t)
  );

  // Base conversion and shift correction.
  fpl10_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (series_ctl),
    .t          (series_t),
    .done       (done),
    .log_scaled (log_scaled)
  );

endmodule

### hdl/fpl10_norm.sv
`timescale 1ns / 1ps
module fpl10_norm (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [fpl10_pkg::INPUT_BITS-1:0]     operand,
  output fpl10_pkg::item_ctl_t                 out_ctl,
  output logic [fpl10_pkg::K_W-1:0]            k
);
  import fpl10_pkg::*;

  logic [SHIFT_W-1:0]         lead_next;
  item_ctl_t                  s1_ctl;
  logic [INPUT_BITS-1:0]      s1_operand;
  logic [INPUT_BITS-1:0]      norm_y;
  item_ctl_t                  s2_ctl;
  logic [SPAN_W-1:0]          s2_x;
  logic [SPAN_W+SCALE_W-1:0]  k_prod;

  // Leading zero count: the highest set bit wins.
  always_comb begin
    lead_next = '0;
    for (int i = 0; i < INPUT_BITS; i++) begin
      if (operand[i]) lead_next = SHIFT_W'(INPUT_BITS - 1 - i);
    end
  end

  // Stage 1: register the operand with its shift count.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid  <= in_valid;
      s1_ctl.zero   <= (operand == '0);
      s1_ctl.shifts <= lead_next;
    end
    s1_operand <= operand;
  end

  // Stage 2: shift the top bit into place and form the gap to full span.
  assign norm_y = s1_operand << s1_ctl.shifts;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl <= s1_ctl;
    end
    s2_x <= SPAN_W'(FULL_SPAN) - {1'b0, norm_y};
  end

  // Stage 3: scale the gap, k = x * 10000 / 65536.
  assign k_prod = s2_x * SCALE_W'(SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= s2_ctl;
    end
    k <= K_W'(k_prod >> KSCALE_SHIFT);
  end

endmodule

### hdl/fpl10_series.sv
`timescale 1ns / 1ps
module fpl10_series (
  input  logic                         clk,
  input  logic                         rst,
  input  fpl10_pkg::item_ctl_t         in_ctl,
  input  logic [fpl10_pkg::K_W-1:0]    k,
  output fpl10_pkg::item_ctl_t         out_ctl,
  output logic [fpl10_pkg::T_W-1:0]    t
);
  import fpl10_pkg::*;

  // Stage A: square and times 33.
  item_ctl_t                 a_ctl;
  logic [K_W-1:0]            a_k;
  logic [SQ_W-1:0]           a_sq;
  logic [K33_W-1:0]          a_k33;
  logic [2*K_W-1:0]          sq_full;
  // Stage B: quotient estimates.
  item_ctl_t                 b_ctl;
  logic [K_W-1:0]            b_k;
  logic [SQ_W-1:0]           b_sq;
  logic [K33_W-1:0]          b_k33;
  logic [Q20_W-1:0]          b_e20;
  logic [Q10_W-1:0]          b_e10;
  logic [Q100K_W-1:0]        b_e100k;
  logic [Q33_W-1:0]          b_e33;
  logic [SQ_W+RECIP_W-1:0]   m20;
  logic [SQ_W+RECIP_W-1:0]   m10;
  logic [SQ_W+RECIP_W-1:0]   m100k;
  logic [K33_W+RECIP_W-1:0]  m33;
  // Stage C: corrected quotients.
  item_ctl_t                 c_ctl;
  logic [K_W-1:0]            c_k;
  logic [Q20_W-1:0]          c_q20;
  logic [Q10_W-1:0]          c_q10;
  logic [Q100K_W-1:0]        c_q100k;
  logic [Q33_W-1:0]          c_q33;
  logic [SQ_W-1:0]           r20;
  logic [SQ_W-1:0]           r10;
  logic [SQ_W-1:0]           r100k;
  logic [K33_W-1:0]          r33;
  // Stage D: cross products.
  item_ctl_t                 d_ctl;
  logic [K_W-1:0]            d_k;
  logic [Q20_W-1:0]          d_q20;
  logic [P1_W-1:0]           d_p1;
  logic [P2_W-1:0]           d_p2;
  // Stage E: estimates of the cross-term quotients.
  item_ctl_t                 e_ctl;
  logic [K_W-1:0]            e_k;
  logic [Q20_W-1:0]          e_q20;
  logic [P1_W-1:0]           e_p1;
  logic [P2_W-1:0]           e_p2;
  logic [P1Q_W-1:0]          e_e1;
  logic [P2Q_W-1:0]          e_e2;
  logic [P1_W+RECIP_W-1:0]   m1;
  logic [P2_W+RECIP_W-1:0]   m2;
  // Stage F: corrected cross-term quotients.
  item_ctl_t                 f_ctl;
  logic [K_W-1:0]            f_k;
  logic [Q20_W-1:0]          f_q20;
  logic [P1Q_W-1:0]          f_q1;
  logic [P2Q_W-1:0]          f_q2;
  logic [P1_W-1:0]           r1;
  logic [P2_W-1:0]           r2;

  // Stage A: k squared and k times 33.
  assign sq_full = k * k;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else begin
      a_ctl <= in_ctl;
    end
    a_k   <= k;
    a_sq  <= SQ_W'(sq_full);
    a_k33 <= K33_W'(k * K33_W'(K33_MUL));
  end

  // Stage B: reciprocal estimates of the four first-level quotients.
  assign m20   = a_sq * RECIP_SQ_A;
  assign m10   = a_sq * RECIP_SQ_B;
  assign m100k = a_sq * RECIP_SQ_C;
  assign m33   = a_k33 * RECIP_K33;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else begin
      b_ctl <= a_ctl;
    end
    b_k     <= a_k;
    b_sq    <= a_sq;
    b_k33   <= a_k33;
    b_e20   <= Q20_W'(m20 >> SQ_W);
    b_e10   <= Q10_W'(m10 >> SQ_W);
    b_e100k <= Q100K_W'(m100k >> SQ_W);
    b_e33   <= Q33_W'(m33 >> K33_W);
  end

  // Stage C: each estimate is at most one low; a remainder at or above
  // the divisor bumps it.
  assign r20   = b_sq - SQ_W'(b_e20 * DIV_SQ_A);
  assign r10   = b_sq - SQ_W'(b_e10 * DIV_SQ_B);
  assign r100k = b_sq - SQ_W'(b_e100k * DIV_SQ_C);
  assign r33   = b_k33 - K33_W'(b_e33 * DIV_K33);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
    end else begin
      c_ctl <= b_ctl;
    end
    c_k     <= b_k;
    c_q20   <= (r20 >= SQ_W'(DIV_SQ_A)) ? b_e20 + Q20_W'(1) : b_e20;
    c_q10   <= (r10 >= SQ_W'(DIV_SQ_B)) ? b_e10 + Q10_W'(1) : b_e10;
    c_q100k <= (r100k >= SQ_W'(DIV_SQ_C)) ? b_e100k + Q100K_W'(1) : b_e100k;
    c_q33   <= (r33 >= K33_W'(DIV_K33)) ? b_e33 + Q33_W'(1) : b_e33;
  end

  // Stage D: products feeding the cubic and quartic terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else begin
      d_ctl <= c_ctl;
    end
    d_k   <= c_k;
    d_q20 <= c_q20;
    d_p1  <= P1_W'(c_q10) * P1_W'(c_q33);
    d_p2  <= P2_W'(c_q100k) * P2_W'(c_q100k);
  end

  // Stage E: reciprocal estimates of the cubic and quartic terms.
  assign m1 = d_p1 * RECIP_P1;
  assign m2 = d_p2 * RECIP_P2;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_ctl <= '0;
    end else begin
      e_ctl <= d_ctl;
    end
    e_k   <= d_k;
    e_q20 <= d_q20;
    e_p1  <= d_p1;
    e_p2  <= d_p2;
    e_e1  <= P1Q_W'(m1 >> P1_W);
    e_e2  <= P2Q_W'(m2 >> P2_W);
  end

  // Stage F: correct the cubic and quartic quotients.
  assign r1 = e_p1 - P1_W'(e_e1 * DIV_P1);
  assign r2 = e_p2 - P2_W'(e_e2 * DIV_P2);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctl <= '0;
    end else begin
      f_ctl <= e_ctl;
    end
    f_k   <= e_k;
    f_q20 <= e_q20;
    f_q1  <= (r1 >= P1_W'(DIV_P1)) ? e_e1 + P1Q_W'(1) : e_e1;
    f_q2  <= (r2 >= P2_W'(DIV_P2)) ? e_e2 + P2Q_W'(1) : e_e2;
  end

  // Stage G: sum of the four series terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= f_ctl;
    end
    t <= T_W'(f_k) + T_W'(f_q20) + T_W'(f_q1) + T_W'(f_q2);
  end

endmodule

### hdl/fpl10_conv.sv
`timescale 1ns / 1ps
module fpl10_conv (
  input  logic                          clk,
  input  logic                          rst,
  input  fpl10_pkg::item_ctl_t          in_ctl,
  input  logic [fpl10_pkg::T_W-1:0]     t,
  output logic                          done,
  output logic [fpl10_pkg::OUT_W-1:0]   log_scaled
);
  import fpl10_pkg::*;

  item_ctl_t                 h_ctl;
  logic [TM_W-1:0]           h_tm;
  item_ctl_t                 i_ctl;
  logic [TM_W-1:0]           i_tm;
  logic [TQ_W-1:0]           i_est;
  logic [TM_W+RECIP_W-1:0]   m_ln10;
  item_ctl_t                 j_ctl;
  logic [TQ_W-1:0]           j_tq;
  logic [TM_W-1:0]           r_ln10;
  logic [OUT_W-1:0]          result_next;

  // Stage H: scale the series sum by 10000.
  always_ff @(posedge clk) begin
    if (rst) begin
      h_ctl <= '0;
    end else begin
      h_ctl <= in_ctl;
    end
    h_tm <= TM_W'(t * TM_W'(SCALE));
  end

  // Stage I: reciprocal estimate of the divide by 2.3025 (times 10000).
  assign m_ln10 = h_tm * RECIP_LN10;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_ctl <= '0;
    end else begin
      i_ctl <= h_ctl;
    end
    i_tm  <= h_tm;
    i_est <= TQ_W'(m_ln10 >> TM_W);
  end

  // Stage J: correct the estimate by one where the remainder allows.
  assign r_ln10 = i_tm - TM_W'(i_est * DIV_LN10);

  always_ff @(posedge clk) begin
    if (rst) begin
      j_ctl <= '0;
    end else begin
      j_ctl <= i_ctl;
    end
    j_tq <= (r_ln10 >= TM_W'(DIV_LN10)) ? i_est + TQ_W'(1) : i_est;
  end

  // Stage K: take the term from the top value and remove 3010 per shift.
  // A zero operand gives zero; an operand with its top bit set has no shift.
  always_comb begin
    if (j_ctl.zero) begin
      result_next = '0;
    end else begin
      result_next = OUT_W'(LOG_TOP) - OUT_W'(j_tq) - OUT_W'(LOG2_STEP * j_ctl.shifts);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= j_ctl.valid;
    end
    log_scaled <= result_next;
  end

endmodule

### hdl/fpl10_checker.sv
`timescale 1ns / 1ps
`include "fixed_point_log10_assert.svh"
module fpl10_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [fpl10_pkg::INPUT_BITS-1:0]    operand,
  input logic                                done,
  input logic [fpl10_pkg::OUT_W-1:0]         log_scaled
);
  import fpl10_pkg::*;

  // Reset holds off new beats and drops any strobe in the next cycle.
  `FPL10_CHECK_NEXT(a_reset_quiet, rst, busy && !done, "reset did not quiet the ports")

  // Every strobe answers a beat taken a fixed number of cycles earlier.
  `FPL10_CHECK(a_done_has_beat, done, $past(start && !busy, PIPE_DEPTH), "result without a beat")

  // A zero operand returns zero.
  `FPL10_CHECK(a_zero_result, done && $past(operand == '0, PIPE_DEPTH), log_scaled == '0,
    "zero operand gave a nonzero result")

  // An operand with its top bit set needs no shift, so the result stays high.
  `FPL10_CHECK(a_top_bit_range,
    done && $past(operand[INPUT_BITS-1], PIPE_DEPTH),
    (log_scaled >= OUT_W'(45204)) && (log_scaled <= OUT_W'(LOG_TOP)),
    "normalized operand result out of range")

endmodule

bind fixed_point_log10 fpl10_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .operand    (operand),
  .done       (done),
  .log_scaled (log_scaled)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fpl10_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 950;
  localparam int DRAIN_CYCLES  = PIPE_DEPTH + 8;
  localparam int TIMEOUT_NS    = 3_000_000;

  // Constants of the series approximation.
  localparam int unsigned TOP_MASK   = 32'h8000;
  localparam int unsigned FIELD_MASK = 32'hFFFF;
  localparam int unsigned SPAN       = 32'h10000;
  localparam int unsigned LN10_DIV   = 23025;
  localparam int unsigned LOG_CEIL   = 48165;
  localparam int unsigned PER_SHIFT  = 3010;

  typedef struct {
    logic [INPUT_BITS-1:0] operand;
    logic [OUT_W-1:0]      log_value;
  } log_expect_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [INPUT_BITS-1:0] operand = '0;
  logic                  busy;
  logic                  done;
  logic [OUT_W-1:0]      log_scaled;

  logic [INPUT_BITS-1:0] pending_operands[$];
  log_expect_t           expected_logs[$];
  int                    burst_left;
  int                    gap_left;
  int                    beats_sent;
  int                    results_checked;
  int                    zero_operands;
  int                    top_set_operands;
  int                    mismatch_total;

  fixed_point_log10 dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operand    (operand),
    .done       (done),
    .log_scaled (log_scaled)
  );

  always #HALF_PERIOD clk = ~clk;

  // Scaled base-10 logarithm: normalize, run the four-term series, convert.
  function automatic logic [OUT_W-1:0] scaled_log10(logic [INPUT_BITS-1:0] value);
    int unsigned norm;
    int unsigned shifts;
    int unsigned k;
    int unsigned sq;
    int unsigned series;
    norm   = value;
    shifts = 0;
    if (value == '0) begin
      return '0;
    end
    while ((norm & TOP_MASK) == 0 && shifts < INPUT_BITS) begin
      norm = (norm << 1) & FIELD_MASK;
      shifts++;
    end
    k      = ((SPAN - norm) * 10000) / 65536;
    sq     = k * k;
    series = k + sq / 20000;
    series += ((sq / 10000) * ((k * 33) / 100)) / 10000;
    series += ((sq / 100000) * (sq / 100000)) / 400;
    return OUT_W'(LOG_CEIL - (series * 10000) / LN10_DIV - PER_SHIFT * shifts);
  endfunction

  // Pick the next burst length; some bursts are long so that back-to-back
  // beats run for a while without any gap.
  function automatic int next_burst();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(40, 120);
    end
    return $urandom_range(1, 16);
  endfunction

  // Driver: present one operand per beat, idling between bursts.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_logs.push_back('{operand, scaled_log10(operand)});
        beats_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_operands.size() != 0) begin
          operand <= pending_operands.pop_front();
          start   <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = next_burst();
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    log_expect_t want;
    if (!rst && done) begin
      if (expected_logs.size() == 0) begin
        $display("%0t: unexpected result beat, log_scaled %0d", $time, log_scaled);
        mismatch_total++;
      end else begin
        want = expected_logs.pop_front();
        results_checked++;
        if (log_scaled !== want.log_value) begin
          $display("%0t: log_scaled for operand 0x%h: expected %0d, actual %0d",
                   $time, want.operand, want.log_value, log_scaled);
          mismatch_total++;
        end
      end
    end
  end

  // Global watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("fixed_point_log10: mismatch");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [INPUT_BITS-1:0] value;
    int                    octave;
    int                    directed;
    int                    pick;
    beats_sent       = 0;
    results_checked  = 0;
    zero_operands    = 0;
    top_set_operands = 0;
    mismatch_total   = 0;
    burst_left       = next_burst();
    gap_left         = 0;

    // Directed operands: zero, field extremes, both sides of the top bit,
    // powers of two and of ten.
    pending_operands = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0000,
                         16'h7FFF, 16'h8000, 16'h8001, 16'hFFFE, 16'hFFFF,
                         16'h4000, 16'h00FF, 16'h0100, 16'h5555, 16'hAAAA,
                         16'd10, 16'd100, 16'd1000, 16'd10000, 16'hC000};
    directed = pending_operands.size();

    // Random operands spread over all normalizing shift counts.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        value = '0;
      end else if (pick < 6) begin
        value = INPUT_BITS'($urandom);
      end else begin
        octave = $urandom_range(0, INPUT_BITS - 1);
        value  = INPUT_BITS'($urandom_range((1 << octave), (2 << octave) - 1));
      end
      pending_operands.push_back(value);
    end
    foreach (pending_operands[i]) begin
      if (pending_operands[i] == '0) zero_operands++;
      if (pending_operands[i][INPUT_BITS-1]) top_set_operands++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Wait until every operand has been taken, then for all results.
    do @(posedge clk); while (pending_operands.size() != 0 || start);
    while (expected_logs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operands (%0d directed), checked %0d results.",
             beats_sent, directed, results_checked);
    $display("Operands included %0d zeros and %0d with the top bit already set.",
             zero_operands, top_set_operands);
    if (mismatch_total == 0) begin
      $display("fixed_point_log10: match");
    end else begin
      $display("fixed_point_log10: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/fpl10_pkg.sv
hdl/fpl10_norm.sv
hdl/fpl10_series.sv
hdl/fpl10_conv.sv
hdl/fixed_point_log10.sv
hdl/fpl10_checker.sv
sim/tb_top.sv
